// ===== src/stb_pkg.sv =====
// Shared types and constants for the software timer bank.
package stb_pkg;

    localparam int MS_PER_SECOND = 1000;
    localparam int TPS_W         = 10;
    localparam int MS_W          = 16;
    localparam int PRODUCT_W     = MS_W + TPS_W;
    localparam int RECIP_SHIFT   = 36;
    localparam int RECIP_W       = 27;
    localparam int TICKS_W       = 17;
    localparam int REMAIN_W      = 18;
    localparam int TAG_W         = 32;
    localparam int COUNT_W       = 64;
    localparam int SLOT_FIELD_W  = 4;
    localparam int MAX_RESULTS   = 16;
    localparam int REP_CNT_W     = 5;
    localparam int IN_DATA_W     = 56;
    localparam int OUT_DATA_W    = 104;

    // Scaled reciprocal of 1000; it gives exact truncated quotients for every product below 2^26.
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << RECIP_SHIFT)
        + 64'(MS_PER_SECOND) - 64'd1) / 64'(MS_PER_SECOND));

    localparam logic [TPS_W-1:0] TPS_RESET = 10'd100;

    typedef enum logic [1:0] {
        ACT_TICK       = 2'd0,
        ACT_REGISTER   = 2'd1,
        ACT_UNREGISTER = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        KIND_REGISTERED   = 3'd0,
        KIND_UNREGISTERED = 3'd1,
        KIND_EXPIRED      = 3'd2,
        KIND_FULL         = 3'd3,
        KIND_NOT_ACTIVE   = 3'd4
    } kind_t;

    typedef struct packed {
        logic                       claim;
        logic                       release_slot;
        logic                       load_remaining;
        logic                       periodic;
        logic [TICKS_W-1:0]         reload;
        logic signed [REMAIN_W-1:0] remaining;
        logic [TAG_W-1:0]           tag;
    } slot_wr_t;

    typedef struct packed {
        logic                       active;
        logic                       periodic;
        logic [TICKS_W-1:0]         reload;
        logic signed [REMAIN_W-1:0] remaining;
        logic [TAG_W-1:0]           tag;
    } slot_rd_t;

endpackage

// ===== src/stb_ms_to_ticks.sv =====
// Millisecond to tick conversion: one multiply, then a multiply by the scaled reciprocal of 1000.
module stb_ms_to_ticks
    import stb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [MS_W-1:0]    duration_ms,
    input  logic [TPS_W-1:0]   ticks_per_second,
    output logic               done,
    output logic [TICKS_W-1:0] ticks
);

    logic                           busy_reg;
    logic                           busy_next;
    logic [PRODUCT_W-1:0]           product_reg;
    logic [PRODUCT_W-1:0]           product_next;
    logic [TICKS_W-1:0]             ticks_reg;
    logic [TICKS_W-1:0]             ticks_next;
    logic [PRODUCT_W+RECIP_W-1:0]   scaled;

    always_comb
    begin
        scaled       = {{RECIP_W{1'b0}}, product_reg} * {{PRODUCT_W{1'b0}}, RECIP};
        busy_next    = 1'b0;
        product_next = product_reg;
        ticks_next   = ticks_reg;
        if (start)
        begin
            busy_next    = 1'b1;
            product_next = {{TPS_W{1'b0}}, duration_ms} * {{MS_W{1'b0}}, ticks_per_second};
        end
        else if (busy_reg)
        begin
            ticks_next = scaled[RECIP_SHIFT +: TICKS_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        product_reg <= product_next;
        ticks_reg   <= ticks_next;
    end

    assign done  = !busy_reg;
    assign ticks = ticks_reg;

endmodule

// ===== src/stb_slot_file.sv =====
// Slot storage with one read port and one write port addressed by the sequencer.
module stb_slot_file
    import stb_pkg::*;
#(
    parameter int NUM_SLOTS = 16,
    parameter int IDX_W     = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] addr,
    input  slot_wr_t         wr,
    output slot_rd_t         rd
);

    logic [NUM_SLOTS-1:0]       active_reg;
    logic [NUM_SLOTS-1:0]       periodic_reg;
    logic [TICKS_W-1:0]         reload_reg    [NUM_SLOTS];
    logic signed [REMAIN_W-1:0] remaining_reg [NUM_SLOTS];
    logic [TAG_W-1:0]           tag_reg       [NUM_SLOTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= '0;
            periodic_reg <= '0;
        end
        else if (wr.claim)
        begin
            active_reg[addr]   <= 1'b1;
            periodic_reg[addr] <= wr.periodic;
        end
        else if (wr.release_slot)
        begin
            active_reg[addr] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.claim)
        begin
            reload_reg[addr]    <= wr.reload;
            remaining_reg[addr] <= wr.remaining;
            tag_reg[addr]       <= wr.tag;
        end
        else if (wr.load_remaining)
        begin
            remaining_reg[addr] <= wr.remaining;
        end
    end

    always_comb
    begin
        rd.active    = active_reg[addr];
        rd.periodic  = periodic_reg[addr];
        rd.reload    = reload_reg[addr];
        rd.remaining = remaining_reg[addr];
        rd.tag       = tag_reg[addr];
    end

endmodule

// ===== src/software_timer_bank.sv =====
// Top level of the software timer bank: item sequencer, tick counter and result register.
//
// Items enter on s_tvalid/s_tready with s_tuser carrying the action (tick, register,
// unregister). Results leave on m_tvalid/m_tready; m_tuser carries the result kind and
// m_tlast marks the final result of an item. The tick rate register is written through
// cfg_wen/cfg_wdata; the user must write it only while the block is idle, which the block itself does not enforce.
// A register item goes through the millisecond to tick conversion (the product of
// duration and tick rate, then a multiply by the scaled reciprocal of 1000), then the
// slot walk looks for a free slot. A tick item walks every slot; the walk visits one
// slot per cycle through the single decrement and compare unit, except while a result
// waits for the output register to be free.
// Items are taken one at a time; s_tready is high only between items.
// A finished result waits in the output register, so the next item can be accepted before
// it is taken. When the receiver stalls, the walk stops at the next result to report
// and resumes once the output register is free; nothing is dropped.
// Reset frees all slots, clears the tick count and sets the tick rate to 100.
// Ticks with no expiry and undefined actions produce no result.
module software_timer_bank
    import stb_pkg::*;
#(
    parameter int NUM_SLOTS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,  // duration_ms, periodic, tag, slot, zero pad
    input  logic [1:0]            s_tuser,  // action
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,  // slot_id, expired_tag, tick_count, zero pad
    output logic [2:0]            m_tuser,  // kind
    output logic                  m_tlast,
    input  logic                  cfg_wen,
    input  logic [TPS_W-1:0]      cfg_wdata
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SEARCH,
        ST_UNREG,
        ST_WALK,
        ST_FLUSH
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    logic [IDX_W-1:0]        idx_reg;
    logic [IDX_W-1:0]        idx_next;
    logic                    periodic_reg;
    logic                    periodic_next;
    logic [TAG_W-1:0]        tag_reg;
    logic [TAG_W-1:0]        tag_next;
    logic [SLOT_FIELD_W-1:0] slot_reg;
    logic [SLOT_FIELD_W-1:0] slot_next;
    logic                    pend_valid_reg;
    logic                    pend_valid_next;
    logic [SLOT_FIELD_W-1:0] pend_slot_reg;
    logic [SLOT_FIELD_W-1:0] pend_slot_next;
    logic [TAG_W-1:0]        pend_tag_reg;
    logic [TAG_W-1:0]        pend_tag_next;
    logic [REP_CNT_W-1:0]    rep_cnt_reg;
    logic [REP_CNT_W-1:0]    rep_cnt_next;
    logic [COUNT_W-1:0]      ticks_elapsed_reg;
    logic [COUNT_W-1:0]      ticks_elapsed_next;
    logic [TPS_W-1:0]        tps_reg;
    logic                    m_tvalid_reg;
    logic                    m_tvalid_next;
    kind_t                   out_kind_reg;
    kind_t                   out_kind_next;
    logic [SLOT_FIELD_W-1:0] out_slot_reg;
    logic [SLOT_FIELD_W-1:0] out_slot_next;
    logic [TAG_W-1:0]        out_tag_reg;
    logic [TAG_W-1:0]        out_tag_next;
    logic [COUNT_W-1:0]      out_count_reg;
    logic [COUNT_W-1:0]      out_count_next;
    logic                    out_last_reg;
    logic                    out_last_next;

    logic                       accept;
    logic                       out_free;
    logic                       push;
    logic                       conv_start;
    logic                       conv_done;
    logic [TICKS_W-1:0]         conv_ticks;
    logic [IDX_W-1:0]           addr;
    logic [IDX_W-1:0]           unreg_addr;
    logic [IDX_W+SLOT_FIELD_W-1:0] unreg_wide;
    logic [IDX_W+SLOT_FIELD_W-1:0] idx_wide;
    logic [SLOT_FIELD_W-1:0]    idx_field;
    logic                       unreg_in_range;
    logic signed [REMAIN_W-1:0] dec;
    logic                       expire;
    slot_wr_t                   wr;
    slot_rd_t                   rd;

    assign accept     = s_tvalid && s_tready;
    assign s_tready   = (state_reg == ST_IDLE);
    assign out_free   = !m_tvalid_reg || m_tready;
    assign conv_start = accept && (action_t'(s_tuser) == ACT_REGISTER);

    assign unreg_wide     = {{IDX_W{1'b0}}, slot_reg};
    assign unreg_addr     = unreg_wide[IDX_W-1:0];
    assign unreg_in_range = ({28'd0, slot_reg} < 32'(NUM_SLOTS));
    assign idx_wide       = {{SLOT_FIELD_W{1'b0}}, idx_reg};
    assign idx_field      = idx_wide[SLOT_FIELD_W-1:0];
    assign addr           = (state_reg == ST_UNREG) ? unreg_addr : idx_reg;

    assign dec    = rd.remaining - 18'sd1;
    assign expire = (dec <= 18'sd0);

    stb_ms_to_ticks u_conv (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (conv_start),
        .duration_ms      (s_tdata[15:0]),
        .ticks_per_second (tps_reg),
        .done             (conv_done),
        .ticks            (conv_ticks)
    );

    stb_slot_file #(
        .NUM_SLOTS (NUM_SLOTS),
        .IDX_W     (IDX_W)
    ) u_slots (
        .clk   (clk),
        .rst_n (rst_n),
        .addr  (addr),
        .wr    (wr),
        .rd    (rd)
    );

    always_comb
    begin
        state_next         = state_reg;
        idx_next           = idx_reg;
        periodic_next      = periodic_reg;
        tag_next           = tag_reg;
        slot_next          = slot_reg;
        pend_valid_next    = pend_valid_reg;
        pend_slot_next     = pend_slot_reg;
        pend_tag_next      = pend_tag_reg;
        rep_cnt_next       = rep_cnt_reg;
        ticks_elapsed_next = ticks_elapsed_reg;
        push               = 1'b0;
        out_kind_next      = out_kind_reg;
        out_slot_next      = out_slot_reg;
        out_tag_next       = out_tag_reg;
        out_count_next     = out_count_reg;
        out_last_next      = out_last_reg;
        wr                 = '0;
        wr.periodic        = periodic_reg;
        wr.reload          = conv_ticks;
        wr.remaining       = $signed({1'b0, conv_ticks});
        wr.tag             = tag_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    periodic_next = s_tdata[16];
                    tag_next      = s_tdata[48:17];
                    slot_next     = s_tdata[52:49];
                    idx_next      = '0;
                    rep_cnt_next  = '0;
                    unique case (s_tuser)
                        ACT_TICK:
                        begin
                            ticks_elapsed_next = ticks_elapsed_reg + 64'd1;
                            state_next         = ST_WALK;
                        end
                        ACT_REGISTER:   state_next = ST_CONVERT;
                        ACT_UNREGISTER: state_next = ST_UNREG;
                        default:        state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CONVERT:
            begin
                if (conv_done)
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (!rd.active)
                begin
                    if (out_free)
                    begin
                        wr.claim      = 1'b1;
                        push          = 1'b1;
                        out_kind_next = KIND_REGISTERED;
                        out_slot_next = idx_field;
                        out_tag_next  = tag_reg;
                        out_last_next = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
                else if (idx_reg == LAST_IDX)
                begin
                    if (out_free)
                    begin
                        push          = 1'b1;
                        out_kind_next = KIND_FULL;
                        out_slot_next = '0;
                        out_tag_next  = tag_reg;
                        out_last_next = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_UNREG:
            begin
                if (out_free)
                begin
                    push          = 1'b1;
                    out_slot_next = slot_reg;
                    out_last_next = 1'b1;
                    state_next    = ST_IDLE;
                    if (unreg_in_range && rd.active)
                    begin
                        wr.release_slot = 1'b1;
                        out_kind_next   = KIND_UNREGISTERED;
                        out_tag_next    = rd.tag;
                    end
                    else
                    begin
                        out_kind_next = KIND_NOT_ACTIVE;
                        out_tag_next  = '0;
                    end
                end
            end
            ST_WALK:
            begin
                // An expiry is held back until the next one is found, so that the final one can carry tlast.
                if (!(rd.active && expire && (rep_cnt_reg < REP_CNT_W'(MAX_RESULTS))
                      && pend_valid_reg && !out_free))
                begin
                    if (rd.active)
                    begin
                        if (!expire)
                        begin
                            wr.load_remaining = 1'b1;
                            wr.remaining      = dec;
                        end
                        else
                        begin
                            if (rd.periodic)
                            begin
                                wr.load_remaining = 1'b1;
                                wr.remaining      = $signed({1'b0, rd.reload});
                            end
                            else
                            begin
                                wr.release_slot = 1'b1;
                            end
                            if (rep_cnt_reg < REP_CNT_W'(MAX_RESULTS))
                            begin
                                if (pend_valid_reg)
                                begin
                                    push          = 1'b1;
                                    out_kind_next = KIND_EXPIRED;
                                    out_slot_next = pend_slot_reg;
                                    out_tag_next  = pend_tag_reg;
                                    out_last_next = 1'b0;
                                end
                                pend_valid_next = 1'b1;
                                pend_slot_next  = idx_field;
                                pend_tag_next   = rd.tag;
                                rep_cnt_next    = rep_cnt_reg + 1'b1;
                            end
                        end
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    push            = 1'b1;
                    out_kind_next   = KIND_EXPIRED;
                    out_slot_next   = pend_slot_reg;
                    out_tag_next    = pend_tag_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (push)
        begin
            out_count_next = ticks_elapsed_reg;
            m_tvalid_next  = 1'b1;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg && !m_tready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            idx_reg           <= '0;
            pend_valid_reg    <= 1'b0;
            rep_cnt_reg       <= '0;
            ticks_elapsed_reg <= '0;
            tps_reg           <= TPS_RESET;
            m_tvalid_reg      <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            idx_reg           <= idx_next;
            pend_valid_reg    <= pend_valid_next;
            rep_cnt_reg       <= rep_cnt_next;
            ticks_elapsed_reg <= ticks_elapsed_next;
            m_tvalid_reg      <= m_tvalid_next;
            if (cfg_wen)
            begin
                tps_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        periodic_reg  <= periodic_next;
        tag_reg       <= tag_next;
        slot_reg      <= slot_next;
        pend_slot_reg <= pend_slot_next;
        pend_tag_reg  <= pend_tag_next;
        out_kind_reg  <= out_kind_next;
        out_slot_reg  <= out_slot_next;
        out_tag_reg   <= out_tag_next;
        out_count_reg <= out_count_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {4'd0, out_count_reg, out_tag_reg, out_slot_reg};

    a_pend_only_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("held expiry left behind after a tick");

    a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> out_free)
        else $error("result pushed over an untaken result");

    a_tick_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tuser == ACT_TICK) |=>
        (ticks_elapsed_reg == $past(ticks_elapsed_reg) + 64'd1))
        else $error("tick count did not advance on a tick");

    a_report_cap: assert property (@(posedge clk) disable iff (!rst_n)
        rep_cnt_reg <= REP_CNT_W'(MAX_RESULTS))
        else $error("more expiries reported than allowed");

endmodule

// ===== test/software_timer_bank_tb.sv =====
// Self-checking testbench for the software timer bank with directed, fill and random traffic.
`timescale 1ns / 1ps

module software_timer_bank_tb;
    import stb_pkg::*;

    localparam int          SLOTS          = 16;
    localparam logic [1:0]  ACT_UNDEFINED  = 2'd3;
    localparam int          SETTLE_CYCLES  = 60;
    localparam int          STALL_LIMIT    = 4000;
    localparam int          HOLD_OFF       = 300;
    localparam int          PRINT_LIMIT    = 50;

    typedef struct {
        kind_t               kind;
        logic [3:0]          slot_id;
        logic [TAG_W-1:0]    tag;
        logic [COUNT_W-1:0]  count;
        logic                last;
    } timer_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [2:0]            m_tuser;
    logic                  m_tlast;
    logic                  cfg_wen;
    logic [TPS_W-1:0]      cfg_wdata;

    bit                    armed [SLOTS];
    bit                    periodic_mode [SLOTS];
    int                    reloads [SLOTS];
    int                    countdown [SLOTS];
    logic [TAG_W-1:0]      tags [SLOTS];
    logic [COUNT_W-1:0]    ticks_seen;
    logic [TPS_W-1:0]      tick_rate;

    timer_result_t         pending_results [$];
    int                    error_count = 0;
    int                    idle_cycles = 0;
    int                    rx_hold = 0;
    int                    rx_stall_pct = 0;
    int                    tx_gap_max = 0;
    int                    burst_left = 0;

    software_timer_bank i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    task automatic flag_error(input string msg);
        if (error_count < PRINT_LIMIT)
        begin
            $display("%0t ERROR: %s", $realtime, msg);
        end
        error_count++;
    endtask

    // Advances the timer table by one accepted item and queues the results it should cause.
    task automatic step_timers(input logic [1:0] act, input logic [15:0] ms,
                               input logic per, input logic [TAG_W-1:0] tg,
                               input logic [3:0] sl);
        timer_result_t r;
        timer_result_t batch [$];
        int unsigned   ticks;
        int            found;

        found = -1;
        if (act == ACT_TICK)
        begin
            ticks_seen = ticks_seen + 1;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (armed[i])
                begin
                    countdown[i]--;
                    if (countdown[i] <= 0)
                    begin
                        r.kind    = KIND_EXPIRED;
                        r.slot_id = i[3:0];
                        r.tag     = tags[i];
                        r.count   = ticks_seen;
                        r.last    = 1'b0;
                        batch.push_back(r);
                        if (periodic_mode[i])
                        begin
                            countdown[i] = reloads[i];
                        end
                        else
                        begin
                            armed[i] = 1'b0;
                        end
                    end
                end
            end
            if (batch.size() > 0)
            begin
                batch[batch.size()-1].last = 1'b1;
            end
            foreach (batch[k])
            begin
                pending_results.push_back(batch[k]);
            end
        end
        else if (act == ACT_REGISTER)
        begin
            ticks = (int'(ms) * int'(tick_rate)) / MS_PER_SECOND;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (!armed[i] && found < 0)
                begin
                    found = i;
                end
            end
            r.tag   = tg;
            r.count = ticks_seen;
            r.last  = 1'b1;
            if (found >= 0)
            begin
                armed[found]         = 1'b1;
                periodic_mode[found] = per;
                reloads[found]       = int'(ticks);
                countdown[found]     = int'(ticks);
                tags[found]          = tg;
                r.kind               = KIND_REGISTERED;
                r.slot_id            = found[3:0];
            end
            else
            begin
                r.kind    = KIND_FULL;
                r.slot_id = 4'd0;
            end
            pending_results.push_back(r);
        end
        else if (act == ACT_UNREGISTER)
        begin
            r.slot_id = sl;
            r.count   = ticks_seen;
            r.last    = 1'b1;
            if (armed[sl])
            begin
                armed[sl] = 1'b0;
                r.kind    = KIND_UNREGISTERED;
                r.tag     = tags[sl];
            end
            else
            begin
                r.kind = KIND_NOT_ACTIVE;
                r.tag  = '0;
            end
            pending_results.push_back(r);
        end
    endtask

    task automatic send_item(input logic [1:0] act, input logic [15:0] ms, input logic per,
                             input logic [TAG_W-1:0] tg, input logic [3:0] sl);
        int gap;

        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 8);
            gap = (tx_gap_max > 0) ? $urandom_range(1, tx_gap_max) : 0;
        end
        burst_left--;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, sl, tg, per, ms};
        s_tuser  <= act;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        step_timers(act, ms, per, tg, sl);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_tick_rate(input logic [TPS_W-1:0] rate);
        wait_drained();
        // A quiet tick may still be walking the slots after the last result.
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= rate;
        @(negedge clk);
        cfg_wen   <= 1'b0;
        tick_rate = rate;
    endtask

    task automatic test_reset_rate_basics();
        send_item(ACT_TICK, 16'd0, 1'b0, '0, 4'd0);
        send_item(ACT_UNDEFINED, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 4'hF);
        send_item(ACT_UNREGISTER, 16'd0, 1'b0, '0, 4'd0);
        send_item(ACT_UNREGISTER, 16'd0, 1'b0, '0, 4'd15);
        send_item(ACT_REGISTER, 16'd0, 1'b1, 32'hFFFF_FFFF, 4'd0);
        send_item(ACT_REGISTER, 16'hFFFF, 1'b0, 32'h0000_0000, 4'd0);
        send_item(ACT_REGISTER, 16'd9, 1'b0, 32'hA5A5_5A5A, 4'd0);
        send_item(ACT_REGISTER, 16'd10, 1'b1, $urandom(), 4'd0);
        send_item(ACT_REGISTER, 16'd25, 1'b0, $urandom(), 4'd0);
        send_item(ACT_TICK, 16'd0, 1'b0, '0, 4'd0);
        send_item(ACT_TICK, 16'd0, 1'b0, '0, 4'd0);
        send_item(ACT_UNREGISTER, 16'd0, 1'b0, '0, 4'd2);
        send_item(ACT_UNREGISTER, 16'd0, 1'b0, '0, 4'd1);
        send_item(ACT_REGISTER, 16'd1000, 1'b0, $urandom(), 4'd0);
        send_item(ACT_UNREGISTER, 16'd0, 1'b0, '0, 4'd0);
        send_item(ACT_UNREGISTER, 16'd0, 1'b0, '0, 4'd3);
        send_item(ACT_UNREGISTER, 16'd0, 1'b0, '0, 4'd1);
    endtask

    // With a zero tick rate every slot expires on the next tick, so one tick reports all slots.
    task automatic test_full_table_burst();
        write_tick_rate(10'd0);
        tx_gap_max   = 2;
        rx_stall_pct = 20;
        for (int i = 0; i <= SLOTS; i++)
        begin
            send_item(ACT_REGISTER, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                      $urandom(), 4'($urandom_range(0, 15)));
        end
        rx_hold = HOLD_OFF;
        send_item(ACT_TICK, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                  $urandom(), 4'd0);
        send_item(ACT_TICK, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                  $urandom(), 4'd0);
        for (int i = 0; i < SLOTS; i++)
        begin
            send_item(ACT_UNREGISTER, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                      $urandom(), i[3:0]);
        end
    endtask

    task automatic test_random_traffic(input logic [TPS_W-1:0] rate, input int count,
                                       input int gap_max, input int stall_pct);
        int          pick;
        int          max_ms;
        logic [1:0]  act;
        logic [15:0] ms;
        logic [3:0]  sl;
        int          live [$];

        write_tick_rate(rate);
        tx_gap_max   = gap_max;
        rx_stall_pct = stall_pct;
        max_ms = (rate == 0) ? 65535 : 8000 / int'(rate);
        if (max_ms > 65535)
        begin
            max_ms = 65535;
        end
        for (int n = 0; n < count; n++)
        begin
            if (n == count / 2)
            begin
                wait_drained();
            end
            pick = $urandom_range(0, 99);
            act  = (pick < 40) ? ACT_TICK : (pick < 75) ? ACT_REGISTER :
                   (pick < 95) ? ACT_UNREGISTER : ACT_UNDEFINED;
            pick = $urandom_range(0, 99);
            ms   = (pick < 5) ? 16'hFFFF : (pick < 15) ? 16'($urandom()) :
                   16'($urandom_range(0, max_ms));
            sl   = 4'($urandom_range(0, 15));
            live.delete();
            for (int i = 0; i < SLOTS; i++)
            begin
                if (armed[i])
                begin
                    live.push_back(i);
                end
            end
            if (act == ACT_UNREGISTER && live.size() > 0 && $urandom_range(0, 99) < 80)
            begin
                sl = 4'(live[$urandom_range(0, live.size() - 1)]);
            end
            send_item(act, ms, ($urandom_range(0, 99) < 30), $urandom(), sl);
        end
    endtask

    initial begin
        int run_left;
        bit stalling;

        run_left = 0;
        stalling = 1'b1;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                rx_hold--;
                m_tready <= 1'b0;
            end
            else
            begin
                if (run_left == 0)
                begin
                    stalling = !stalling && ($urandom_range(0, 99) < rx_stall_pct);
                    run_left = stalling ? $urandom_range(1, 6) : $urandom_range(1, 12);
                end
                run_left--;
                m_tready <= !stalling;
            end
        end
    end

    always @(posedge clk)
    begin
        timer_result_t want;

        if (m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                flag_error($sformatf("unexpected result kind %0d slot %0d",
                                     m_tuser, m_tdata[3:0]));
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tuser !== want.kind)
                    flag_error($sformatf("kind %0d, expected %0d", m_tuser, want.kind));
                if (m_tdata[3:0] !== want.slot_id)
                    flag_error($sformatf("slot %0d, expected %0d", m_tdata[3:0], want.slot_id));
                if (m_tdata[35:4] !== want.tag)
                    flag_error($sformatf("tag %h, expected %h", m_tdata[35:4], want.tag));
                if (m_tdata[99:36] !== want.count)
                    flag_error($sformatf("tick count %0d, expected %0d",
                                         m_tdata[99:36], want.count));
                if (m_tlast !== want.last)
                    flag_error($sformatf("last %b, expected %b", m_tlast, want.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        cfg_wen    = 1'b0;
        cfg_wdata  = '0;
        ticks_seen = '0;
        tick_rate  = TPS_RESET;
        for (int i = 0; i < SLOTS; i++)
        begin
            armed[i]         = 1'b0;
            periodic_mode[i] = 1'b0;
            reloads[i]       = 0;
            countdown[i]     = 0;
            tags[i]          = '0;
        end
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        test_reset_rate_basics();
        test_full_table_burst();
        test_random_traffic(10'd1, 65, 0, 0);
        test_random_traffic(10'd1000, 65, 4, 30);
        test_random_traffic(10'd1023, 65, 8, 50);
        test_random_traffic(10'($urandom_range(2, 999)), 65, 3, 20);
        test_random_traffic(TPS_RESET, 65, 2, 60);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
